FILE: rtl/dmrl_pkg.sv
// shared types and constants of the dot-matrix row loader
`default_nettype none

package dmrl_pkg;

  typedef enum logic [1:0] {
    ACT_CONTROL    = 2'd0,
    ACT_MUX        = 2'd1,
    ACT_COMM_READ  = 2'd2,
    ACT_HOST_WRITE = 2'd3
  } action_t;

  localparam int unsigned ROW_BYTES = 9;
  localparam logic [3:0] ROW_BYTES_CNT = 4'(ROW_BYTES);
  localparam logic [3:0] LAST_IDX = 4'(ROW_BYTES - 1);
  localparam logic [7:0] ROW_MASK = 8'h7C;
  localparam logic [7:0] LAST_MASK = 8'h80;
  localparam int unsigned DOTS_PER_ROW = 65;
  localparam int unsigned HALF_DOTS = (DOTS_PER_ROW - 1) / 2;

  typedef logic [7:0] scan_row_t [ROW_BYTES];

  typedef struct packed {
    logic [7:0]           read_byte;
    logic                 busy_line;
    logic                 data_pending;
    logic                 row_strobe;
    logic [4:0]           row_index;
    logic [HALF_DOTS-1:0] dots_first;
    logic [HALF_DOTS-1:0] dots_second;
    logic                 dot_last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/dmrl_in_if.sv
// bus access channel: valid/ready with action and data byte
`default_nettype none

interface dmrl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/dmrl_out_if.sv
// result channel: valid/ready with the per-access result fields
`default_nettype none

interface dmrl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic        busy_line;
  logic        data_pending;
  logic        row_strobe;
  logic [4:0]  row_index;
  logic [31:0] dots_first;
  logic [31:0] dots_second;
  logic        dot_last;

  modport source (
    output valid, output read_byte, output busy_line, output data_pending,
    output row_strobe, output row_index, output dots_first, output dots_second,
    output dot_last, input ready
  );
  modport sink (
    input valid, input read_byte, input busy_line, input data_pending,
    input row_strobe, input row_index, input dots_first, input dots_second,
    input dot_last, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/dmrl_core.sv
// register file state and single-pass decode of one bus access
`default_nettype none

module dmrl_core #(
  parameter int ROW_COUNT = 21
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [1:0]        action,
  input  wire logic [7:0]        data_byte,
  output dmrl_pkg::result_t      res
);

  localparam logic [5:0] ROW_LIMIT = 6'(ROW_COUNT);

  logic [7:0]         control_value;
  logic [7:0]         control_value_next;
  logic [3:0]         column_count;
  logic [3:0]         column_count_next;
  dmrl_pkg::scan_row_t scan_bytes;
  dmrl_pkg::scan_row_t scan_bytes_next;
  logic               busy_flag;
  logic               busy_flag_next;
  logic [7:0]         host_byte;
  logic [7:0]         host_byte_next;
  logic               pending_flag;
  logic               pending_flag_next;

  dmrl_pkg::action_t  act;
  logic [7:0]         changed;
  logic [4:0]         row;
  logic               row_full;

  assign act     = dmrl_pkg::action_t'(action);
  assign changed = control_value ^ data_byte;
  assign row     = ~data_byte[6:2];

  always_comb begin
    control_value_next = control_value;
    column_count_next  = column_count;
    scan_bytes_next    = scan_bytes;
    busy_flag_next     = busy_flag;
    host_byte_next     = host_byte;
    pending_flag_next  = pending_flag;
    row_full           = 1'b0;
    res                = '0;
    unique case (act)
      dmrl_pkg::ACT_CONTROL: begin
        control_value_next = data_byte;
        if (changed[1] && !data_byte[1]) begin
          column_count_next = '0;
        end
        if (changed[3]) begin
          busy_flag_next = ~data_byte[3];
        end
      end
      dmrl_pkg::ACT_MUX: begin
        if (column_count < dmrl_pkg::ROW_BYTES_CNT) begin
          scan_bytes_next[column_count] = data_byte;
          column_count_next = column_count + 4'd1;
        end
        row_full = (column_count_next == dmrl_pkg::ROW_BYTES_CNT);
        if (row_full) begin
          scan_bytes_next[dmrl_pkg::LAST_IDX] =
            scan_bytes_next[dmrl_pkg::LAST_IDX] & dmrl_pkg::LAST_MASK;
          if ({1'b0, row} < ROW_LIMIT) begin
            res.row_strobe = 1'b1;
            res.row_index  = row;
            for (int k = 0; k < 4; k++) begin
              for (int j = 0; j < 8; j++) begin
                res.dots_first[8*k + j]  = scan_bytes_next[k][7-j];
                res.dots_second[8*k + j] = scan_bytes_next[k+4][7-j];
              end
            end
            res.dot_last = scan_bytes_next[dmrl_pkg::LAST_IDX][7];
          end
        end
      end
      dmrl_pkg::ACT_COMM_READ: begin
        if (pending_flag) begin
          res.read_byte     = host_byte;
          pending_flag_next = 1'b0;
        end
      end
      dmrl_pkg::ACT_HOST_WRITE: begin
        host_byte_next    = data_byte;
        pending_flag_next = 1'b1;
      end
      default: begin
      end
    endcase
    res.busy_line    = busy_flag_next;
    res.data_pending = pending_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_value <= '0;
      column_count  <= '0;
      busy_flag     <= 1'b0;
      host_byte     <= '0;
      pending_flag  <= 1'b0;
      for (int i = 0; i < dmrl_pkg::ROW_BYTES; i++) begin
        scan_bytes[i] <= '0;
      end
    end else if (fire) begin
      control_value <= control_value_next;
      column_count  <= column_count_next;
      busy_flag     <= busy_flag_next;
      host_byte     <= host_byte_next;
      pending_flag  <= pending_flag_next;
      scan_bytes    <= scan_bytes_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dmrl_out_stage.sv
// result register driving the output channel
`default_nettype none

module dmrl_out_stage (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire dmrl_pkg::result_t res,
  output logic              can_take,
  dmrl_out_if.source        result
);

  logic              valid;
  dmrl_pkg::result_t held;

  assign can_take = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign result.valid        = valid;
  assign result.read_byte    = held.read_byte;
  assign result.busy_line    = held.busy_line;
  assign result.data_pending = held.data_pending;
  assign result.row_strobe   = held.row_strobe;
  assign result.row_index    = held.row_index;
  assign result.dots_first   = held.dots_first;
  assign result.dots_second  = held.dots_second;
  assign result.dot_last     = held.dot_last;

endmodule

`default_nettype wire

FILE: rtl/dot_matrix_row_loader.sv
// top level of the dot-matrix row loader
//
// bus carries one register access per transfer: action selects control
// write, mux write, comm read or host data write; data_byte is the byte.
// result returns exactly one item per access: comm read data, busy line,
// pending flag, and on each mux write to a full scanline row whose row
// index is below ROW_COUNT the row strobe, row index and 65 dots.
// an accepted access waits in the input register, is decoded against the
// display state and lands in the result register when that register can
// take it; the result is then held there until the receiver takes it.
// throughput is one access per cycle while results are taken; the input
// register still accepts one access while a finished result waits.
// when the receiver stalls, the result register holds and the input
// register fills; bus ready then drops until the result is taken.
// synchronous reset clears control, counter, scanline bytes, busy line,
// host byte and pending flag, and empties both registers.
`default_nettype none

module dot_matrix_row_loader #(
  parameter int ROW_COUNT = 21
) (
  input  wire logic  clk,
  input  wire logic  rst,
  dmrl_in_if.sink    bus,
  dmrl_out_if.source result
);

  logic              stage_valid;
  logic [1:0]        stage_action;
  logic [7:0]        stage_data;
  logic              can_take;
  logic              advance;
  dmrl_pkg::result_t res;

  assign advance   = stage_valid && can_take;
  assign bus.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (bus.ready) begin
      stage_valid <= bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bus.valid && bus.ready) begin
      stage_action <= bus.action;
      stage_data   <= bus.data_byte;
    end
  end

  dmrl_core #(
    .ROW_COUNT (ROW_COUNT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .action    (stage_action),
    .data_byte (stage_data),
    .res       (res)
  );

  dmrl_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res      (res),
    .can_take (can_take),
    .result   (result)
  );

  a_strobe_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.row_strobe |-> 32'(result.row_index) < 32'(ROW_COUNT))
    else $error("row strobe with row index out of range");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.row_strobe |->
      result.row_index == '0 && result.dots_first == '0 &&
      result.dots_second == '0 && !result.dot_last)
    else $error("row fields set without a row strobe");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_action) && $stable(stage_data))
    else $error("input register lost a waiting access");

  a_read_clears_pending: assert property (@(posedge clk) disable iff (rst)
    advance && stage_action == dmrl_pkg::ACT_COMM_READ |-> !res.data_pending)
    else $error("comm read left pending set");

endmodule

`default_nettype wire

FILE: verif/dmrl_checker.sv
`timescale 1ns / 1ps
// checker for the dot-matrix row loader: predicts each access result and compares it
module dmrl_checker
  import dmrl_pkg::*;
#(
  parameter int ROW_COUNT = 21
) (
  input  logic        clk,
  input  logic        rst,
  dmrl_in_if          bus,
  dmrl_out_if         result,
  output int unsigned error_count,
  output int unsigned results_left,
  output int unsigned result_count,
  output int unsigned strobe_count
);

  logic [7:0] control_q;
  logic [3:0] column_q;
  logic [7:0] scan_q [ROW_BYTES];
  logic       busy_q;
  logic [7:0] host_q;
  logic       pending_q;

  result_t due_results[$];

  task automatic decode_access(input action_t act, input logic [7:0] d, output result_t r);
    logic [7:0]  changed;
    logic [4:0]  row;
    logic [63:0] dots;
    int          i;
    r = '0;
    case (act)
      ACT_CONTROL: begin
        changed = control_q ^ d;
        control_q = d;
        if (changed[1] && !d[1]) column_q = '0;
        if (changed[3]) busy_q = ~d[3];
      end
      ACT_MUX: begin
        if (column_q < ROW_BYTES_CNT) begin
          scan_q[column_q] = d;
          column_q = column_q + 4'd1;
        end
        if (column_q == ROW_BYTES_CNT) begin
          row = 5'((~d & ROW_MASK) >> 2);
          scan_q[LAST_IDX] = scan_q[LAST_IDX] & LAST_MASK;
          if (int'(row) < ROW_COUNT) begin
            for (i = 0; i < 64; i++) dots[i] = scan_q[i / 8][7 - (i % 8)];
            r.row_strobe = 1'b1;
            r.row_index = row;
            r.dots_first = dots[31:0];
            r.dots_second = dots[63:32];
            r.dot_last = scan_q[LAST_IDX][7];
          end
        end
      end
      ACT_COMM_READ: begin
        if (pending_q) begin
          r.read_byte = host_q;
          pending_q = 1'b0;
        end
      end
      default: begin
        host_q = d;
        pending_q = 1'b1;
      end
    endcase
    r.busy_line = busy_q;
    r.data_pending = pending_q;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t r;
    result_t want;
    if (rst) begin
      control_q = '0;
      column_q = '0;
      foreach (scan_q[k]) scan_q[k] = '0;
      busy_q = 1'b0;
      host_q = '0;
      pending_q = 1'b0;
      due_results.delete();
      error_count = 0;
      result_count = 0;
      strobe_count = 0;
    end else begin
      if (bus.valid && bus.ready) begin
        decode_access(action_t'(bus.action), bus.data_byte, r);
        due_results.push_back(r);
      end
      if (result.valid && result.ready) begin
        result_count++;
        if (due_results.size() == 0) begin
          $error("result transfer with no access waiting");
          error_count++;
        end else begin
          want = due_results.pop_front();
          check_field("read_byte", want.read_byte, result.read_byte);
          check_field("busy_line", want.busy_line, result.busy_line);
          check_field("data_pending", want.data_pending, result.data_pending);
          check_field("row_strobe", want.row_strobe, result.row_strobe);
          check_field("row_index", want.row_index, result.row_index);
          check_field("dots_first", want.dots_first, result.dots_first);
          check_field("dots_second", want.dots_second, result.dots_second);
          check_field("dot_last", want.dot_last, result.dot_last);
          if (want.row_strobe) strobe_count++;
        end
      end
    end
    results_left = due_results.size();
  end

endmodule

FILE: verif/dot_matrix_row_loader_tb.sv
`timescale 1ns / 1ps
// testbench top of the dot-matrix row loader: stimulus, flow control and verdict
module dot_matrix_row_loader_tb;
  import dmrl_pkg::*;

  localparam int ROW_COUNT = 21;
  localparam int ACCESS_TARGET = 550;
  localparam int QUIET_FROM = 480;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 48;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst;
  int unsigned error_count;
  int unsigned results_left;
  int unsigned result_count;
  int unsigned strobe_count;
  int unsigned sent_count;
  int unsigned cycle_count;
  bit          quiet;
  bit          hold_req;

  dmrl_in_if  bus_ch ();
  dmrl_out_if result_ch ();

  dot_matrix_row_loader #(.ROW_COUNT(ROW_COUNT)) uut (
    .clk    (clk),
    .rst    (rst),
    .bus    (bus_ch),
    .result (result_ch)
  );

  dmrl_checker #(.ROW_COUNT(ROW_COUNT)) chk (
    .clk          (clk),
    .rst          (rst),
    .bus          (bus_ch),
    .result       (result_ch),
    .error_count  (error_count),
    .results_left (results_left),
    .result_count (result_count),
    .strobe_count (strobe_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_access(input action_t act, input logic [7:0] d);
    bus_ch.valid <= 1'b1;
    bus_ch.action <= act;
    bus_ch.data_byte <= d;
    do @(posedge clk); while (!bus_ch.ready);
    sent_count++;
    if (sent_count == HOLD_AT) hold_req = 1'b1;
    if (sent_count >= QUIET_FROM) quiet = 1'b1;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      bus_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // receiver flow control
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        result_ch.ready <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 20)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("dot_matrix_row_loader_tb: errors");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    bus_ch.valid <= 1'b0;
    bus_ch.action <= ACT_CONTROL;
    bus_ch.data_byte <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // comm reads with and without a pending byte, host overwrite
    send_access(ACT_COMM_READ, 8'h00);
    send_access(ACT_HOST_WRITE, 8'hA5);
    send_access(ACT_HOST_WRITE, 8'h5A);
    send_access(ACT_COMM_READ, 8'hFF);
    send_access(ACT_COMM_READ, 8'h00);
    send_access(ACT_HOST_WRITE, 8'hFF);
    send_access(ACT_COMM_READ, 8'h00);
    send_access(ACT_HOST_WRITE, 8'h00);
    // busy line and column clear
    send_access(ACT_CONTROL, 8'h08);
    send_access(ACT_CONTROL, 8'h00);
    send_access(ACT_CONTROL, 8'hFF);
    send_access(ACT_CONTROL, 8'hFF);
    send_access(ACT_CONTROL, 8'h00);
    // one full row, then writes on a full row
    send_access(ACT_MUX, 8'hFF);
    send_access(ACT_MUX, 8'h00);
    send_access(ACT_MUX, 8'h80);
    send_access(ACT_MUX, 8'h01);
    send_access(ACT_MUX, 8'hAA);
    send_access(ACT_MUX, 8'h55);
    send_access(ACT_MUX, 8'h7F);
    send_access(ACT_MUX, 8'hFE);
    send_access(ACT_MUX, 8'hFF);
    send_access(ACT_MUX, 8'h00);
    send_access(ACT_MUX, 8'h2B);
    send_access(ACT_MUX, 8'h2F);
    send_access(ACT_COMM_READ, 8'h00);

    while (sent_count < ACCESS_TARGET) begin
      if ($urandom_range(0, 9) < 7) begin
        send_access(ACT_CONTROL, 8'($urandom) | 8'h02);
        send_access(ACT_CONTROL, 8'($urandom) & 8'hFD);
        repeat (ROW_BYTES) begin
          if ($urandom_range(0, 6) == 0)
            send_access(action_t'($urandom_range(2, 3)), 8'($urandom));
          send_access(ACT_MUX, 8'($urandom));
        end
        repeat ($urandom_range(0, 3)) send_access(ACT_MUX, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          send_access(action_t'($urandom_range(0, 3)), 8'($urandom));
      end
    end

    bus_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d bus accesses driven, %0d results checked, %0d of them row strobes",
             sent_count, result_count, strobe_count);
    if (error_count == 0) begin
      $display("dot_matrix_row_loader_tb: clean");
    end else begin
      $display("dot_matrix_row_loader_tb: errors");
    end
    $finish;
  end

endmodule
